>>> rtl/core/ncl_pkg.sv
// Shared constants, types and register codes of the nearest class labeller.
package ncl_pkg;

   // Channel and register geometry
   localparam int unsigned NUM_CLASSES = 4;
   localparam int unsigned DIST_W      = 17;
   localparam int unsigned THR_W       = 13;
   localparam int unsigned CNT_W       = 3;
   localparam int unsigned LABEL_W     = 3;
   localparam int unsigned CLASS_IDX_W = 2;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned PROD_W      = 2 * THR_W;

   typedef logic [DIST_W-1:0]      dist_type;
   typedef logic [THR_W-1:0]       thr_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [LABEL_W-1:0]     label_type;
   typedef logic [CLASS_IDX_W-1:0] class_idx_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [PROD_W-1:0]      prod_type;

   // Register indexes: thresholds occupy 0 .. NUM_CLASSES-1
   localparam csr_idx_type CSR_THRESHOLD_BASE = 3'd0;
   localparam csr_idx_type CSR_CLASS_COUNT    = 3'd4;

   // Reset values: 0.3 in Q1.12, all classes in use
   localparam thr_type THR_RESET = 13'd1229;
   localparam cnt_type CNT_RESET = 3'd4;

   // Running decision handed from cell to cell, with the request's distances
   typedef struct packed {
      logic                             skip;
      logic                             have;
      thr_type                          best_num;
      thr_type                          best_den;
      class_idx_type                    best_idx;
      logic [NUM_CLASSES-1:0][DIST_W-1:0] distances;
   } chain_type;

endpackage

>>> rtl/core/ncl_req_if.sv
// Request channel: one distance per class for a single time point.
interface ncl_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [ncl_pkg::DIST_W-1:0] distance_class_0;
   logic signed [ncl_pkg::DIST_W-1:0] distance_class_1;
   logic signed [ncl_pkg::DIST_W-1:0] distance_class_2;
   logic signed [ncl_pkg::DIST_W-1:0] distance_class_3;

   modport source (
      output valid, distance_class_0, distance_class_1, distance_class_2, distance_class_3,
      input  ready
   );
   modport sink (
      input  valid, distance_class_0, distance_class_1, distance_class_2, distance_class_3,
      output ready
   );
endinterface

>>> rtl/core/ncl_rsp_if.sv
// Response channel: the class label of one time point.
interface ncl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ncl_pkg::LABEL_W-1:0]   label;

   modport source (
      output valid, label,
      input  ready
   );
   modport sink (
      input  valid, label,
      output ready
   );
endinterface

>>> rtl/core/ncl_cell.sv
// One class cell: scores its own class and keeps the best class so far.
module ncl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ncl_pkg::class_idx_type cell_idx,
   input  logic                   active,
   input  ncl_pkg::thr_type       threshold,
   input  ncl_pkg::dist_type      distance,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ncl_pkg::chain_type     in_state,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ncl_pkg::chain_type     out_state
);

   logic                     valid_ff, valid_in;
   ncl_pkg::chain_type       state_ff, state_in;
   logic [ncl_pkg::DIST_W-2:0] thr_ext;
   logic                     qualify;
   logic                     thr_zero;
   ncl_pkg::thr_type         num_new, den_new;
   ncl_pkg::prod_type        prod_new, prod_best;
   logic                     better;

   // Qualify: cell active, no skip, distance non-negative and within the threshold
   assign thr_ext = {{(ncl_pkg::DIST_W-1-ncl_pkg::THR_W){1'b0}}, threshold};
   assign qualify = active && !in_state.skip && !distance[ncl_pkg::DIST_W-1]
                    && (distance[ncl_pkg::DIST_W-2:0] <= thr_ext);

   // Score as a fraction; a zero threshold at zero distance scores one
   assign thr_zero = (threshold == '0);
   assign num_new  = thr_zero ? ncl_pkg::thr_type'(1)
                              : threshold - distance[ncl_pkg::THR_W-1:0];
   assign den_new  = thr_zero ? ncl_pkg::thr_type'(1) : threshold;

   // Compare scores exactly by cross multiplication
   assign prod_new  = {{ncl_pkg::THR_W{1'b0}}, num_new} *
                      {{ncl_pkg::THR_W{1'b0}}, in_state.best_den};
   assign prod_best = {{ncl_pkg::THR_W{1'b0}}, in_state.best_num} *
                      {{ncl_pkg::THR_W{1'b0}}, den_new};
   assign better    = !in_state.have || (prod_new > prod_best);

   // Take over the lead on a strictly better score, so the lower class keeps ties
   always_comb begin
      state_in = in_state;
      if (qualify && better) begin
         state_in.have     = 1'b1;
         state_in.best_num = num_new;
         state_in.best_den = den_new;
         state_in.best_idx = cell_idx;
      end
   end

   // Advance when the stage is empty or its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

>>> rtl/core/nearest_class_threshold_labeler_core.sv
// Top level of the nearest class labeller: register file and chain of class cells.
//
// Usage:
//   req_chan carries one time point: a signed Q4.12 distance for each of the four
//   classes. rsp_chan returns one 3-bit label per request, in request order:
//   0 when class 0's distance is negative or no class qualifies, otherwise the
//   winning class index plus one (best score, lowest class on a tie).
//   csr_we/csr_index/csr_wdata write a register: indexes 0..3 are the Q1.12 class
//   thresholds, index 4 the number of classes in use. Write only while no request
//   is in flight.
// Throughput:
//   a request passes one cell per class; each cell holds one request and hands its
//   decision on. One request is taken every cycle unless a stall on rsp_chan has
//   filled the chain.
// Reset:
//   empties the chain, sets every threshold to 1229 (0.3) and the class count to 4.
// Stall:
//   while rsp_chan.ready is low the last cell holds its label; earlier cells keep
//   filling until the chain is full, and only then does req_chan.ready drop.
module nearest_class_threshold_labeler_core (
   input  logic                        clock,
   input  logic                        reset,
   ncl_req_if.sink                     req_chan,
   ncl_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  ncl_pkg::csr_idx_type        csr_index,
   input  logic [ncl_pkg::THR_W-1:0]   csr_wdata
);

   ncl_pkg::thr_type   thr_ff [ncl_pkg::NUM_CLASSES];
   ncl_pkg::thr_type   thr_in [ncl_pkg::NUM_CLASSES];
   ncl_pkg::cnt_type   count_ff, count_in;

   ncl_pkg::chain_type chain_state [ncl_pkg::NUM_CLASSES+1];
   logic [ncl_pkg::NUM_CLASSES:0] chain_valid;
   logic [ncl_pkg::NUM_CLASSES:0] chain_ready;
   ncl_pkg::chain_type last_state;

   // Decode register writes
   always_comb begin
      thr_in   = thr_ff;
      count_in = count_ff;
      if (csr_we) begin
         priority if (csr_index < ncl_pkg::CSR_CLASS_COUNT) begin
            thr_in[csr_index[ncl_pkg::CLASS_IDX_W-1:0] - ncl_pkg::CSR_THRESHOLD_BASE
                   [ncl_pkg::CLASS_IDX_W-1:0]] = csr_wdata;
         end else if (csr_index == ncl_pkg::CSR_CLASS_COUNT) begin
            count_in = csr_wdata[ncl_pkg::CNT_W-1:0];
         end else begin
            count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ncl_pkg::NUM_CLASSES; i++) begin
            thr_ff[i] <= ncl_pkg::THR_RESET;
         end
         count_ff <= ncl_pkg::CNT_RESET;
      end else begin
         thr_ff   <= thr_in;
         count_ff <= count_in;
      end
   end

   // Seed the chain: skip flag from class 0, no class yet
   always_comb begin
      chain_state[0].skip      = req_chan.distance_class_0[ncl_pkg::DIST_W-1];
      chain_state[0].have      = 1'b0;
      chain_state[0].best_num  = '0;
      chain_state[0].best_den  = ncl_pkg::thr_type'(1);
      chain_state[0].best_idx  = '0;
      chain_state[0].distances = {req_chan.distance_class_3, req_chan.distance_class_2,
                                  req_chan.distance_class_1, req_chan.distance_class_0};
   end
   assign chain_valid[0] = req_chan.valid;
   assign req_chan.ready = chain_ready[0];

   // One cell per class; a cell above the class count passes the decision on
   for (genvar k = 0; k < ncl_pkg::NUM_CLASSES; k++) begin : g_cell
      logic cell_active;
      assign cell_active = (k == 0) || (ncl_pkg::cnt_type'(k) < count_ff);

      ncl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (ncl_pkg::class_idx_type'(k)),
         .active    (cell_active),
         .threshold (thr_ff[k]),
         .distance  (chain_state[k].distances[k]),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_state  (chain_state[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_state (chain_state[k+1])
      );
   end

   // Form the label from the last cell
   assign last_state = chain_state[ncl_pkg::NUM_CLASSES];
   assign chain_ready[ncl_pkg::NUM_CLASSES] = rsp_chan.ready;
   assign rsp_chan.valid = chain_valid[ncl_pkg::NUM_CLASSES];
   assign rsp_chan.label = (last_state.skip || !last_state.have) ? '0 :
                           ncl_pkg::label_type'(last_state.best_idx) + ncl_pkg::label_type'(1);

`ifndef SYNTHESIS
   // A winning class lies within the classes in use
   label_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.label != '0) |->
         (rsp_chan.label == ncl_pkg::label_type'(1)) || (rsp_chan.label <= count_ff))
      else $error("label names a class beyond the class count");

   // A held score has a non-zero denominator and is no larger than one
   score_sane: assert property (@(posedge clock) disable iff (reset)
      chain_valid[ncl_pkg::NUM_CLASSES] && last_state.have && !last_state.skip |->
         (last_state.best_den != '0) && (last_state.best_num <= last_state.best_den))
      else $error("best score has zero denominator or exceeds one");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench of the nearest class threshold labeller: stimulus, label prediction and checking.
module tb;

   typedef logic [ncl_pkg::NUM_CLASSES-1:0][ncl_pkg::DIST_W-1:0] point_type;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 4 * ncl_pkg::NUM_CLASSES;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned POINTS_PER_PHASE = 200;

   // Holds the register copy and the labels still owed by the block
   class label_checker;
      ncl_pkg::thr_type   thr [ncl_pkg::NUM_CLASSES];
      ncl_pkg::cnt_type   count;
      ncl_pkg::label_type pending_labels [$];
      int unsigned mismatches;
      int unsigned skipped;
      int unsigned label_seen [8];

      function new();
         foreach (thr[c]) thr[c] = ncl_pkg::THR_RESET;
         count = ncl_pkg::CNT_RESET;
      endfunction

      function void write_reg(ncl_pkg::csr_idx_type idx, logic [ncl_pkg::THR_W-1:0] data);
         if (idx < ncl_pkg::NUM_CLASSES)
            thr[idx[ncl_pkg::CLASS_IDX_W-1:0]] = data;
         else if (idx == ncl_pkg::CSR_CLASS_COUNT)
            count = data[ncl_pkg::CNT_W-1:0];
      endfunction

      // Best score by cross multiplication, lowest class on a tie
      function ncl_pkg::label_type nearest_label(point_type pt);
         int unsigned n;
         bit have;
         int unsigned best;
         longint unsigned best_num, best_den, num, den;
         longint d, t;
         have = 1'b0;
         best = 0;
         best_num = 0;
         best_den = 1;
         n = count;
         if (n == 0) n = 1;
         if (n > ncl_pkg::NUM_CLASSES) n = ncl_pkg::NUM_CLASSES;
         if ($signed(pt[0]) < 0) begin
            skipped++;
            return '0;
         end
         for (int unsigned c = 0; c < n; c++) begin
            d = $signed(pt[c]);
            t = thr[c];
            if (d < 0 || d > t) continue;
            // A zero threshold at distance zero counts as a perfect score
            if (t == 0) begin
               num = 1;
               den = 1;
            end else begin
               num = t - d;
               den = t;
            end
            if (!have || num * best_den > best_num * den) begin
               have = 1'b1;
               best_num = num;
               best_den = den;
               best = c;
            end
         end
         return have ? ncl_pkg::label_type'(best + 1) : ncl_pkg::label_type'(0);
      endfunction

      function void note_point(point_type pt);
         pending_labels.push_back(nearest_label(pt));
      endfunction

      function void check_label(ncl_pkg::label_type got);
         ncl_pkg::label_type want;
         label_seen[got]++;
         if (pending_labels.size() == 0) begin
            $error("label: no request outstanding, actual %0d", got);
            mismatches++;
            return;
         end
         want = pending_labels.pop_front();
         if (got !== want) begin
            $error("label: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return pending_labels.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   ncl_pkg::csr_idx_type csr_index;
   logic [ncl_pkg::THR_W-1:0] csr_wdata;
   bit idle_on;
   int unsigned points_sent;
   int unsigned settings_used;
   int unsigned idle_cycles;

   label_checker book = new();

   ncl_req_if req_bus ();
   ncl_rsp_if rsp_bus ();

   nearest_class_threshold_labeler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly back to back, sometimes a short pause, rarely a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic point_type mk(int a, int b, int c, int d);
      point_type pt;
      pt[0] = ncl_pkg::dist_type'(a);
      pt[1] = ncl_pkg::dist_type'(b);
      pt[2] = ncl_pkg::dist_type'(c);
      pt[3] = ncl_pkg::dist_type'(d);
      return pt;
   endfunction

   // Bias distances towards the qualifying window of the lane's threshold
   function automatic ncl_pkg::dist_type pick_distance(ncl_pkg::thr_type t);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return ncl_pkg::dist_type'($urandom_range(t, 0));
      if (r < 50) return $urandom_range(1) ? ncl_pkg::dist_type'(t) : ncl_pkg::dist_type'(0);
      if (r < 62) return ncl_pkg::dist_type'(-int'($urandom_range(65536, 1)));
      if (r < 77) return ncl_pkg::dist_type'($urandom_range(65535, t + 1));
      return ncl_pkg::dist_type'($urandom);
   endfunction

   function automatic ncl_pkg::thr_type pick_threshold();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 25) return ncl_pkg::thr_type'(4096);
      if (r < 35) return '1;
      if (r < 40) return ncl_pkg::thr_type'(1);
      if (r < 80) return ncl_pkg::thr_type'($urandom_range(4096, 0));
      return ncl_pkg::thr_type'($urandom_range(8191, 0));
   endfunction

   function automatic logic [ncl_pkg::THR_W-1:0] pick_count();
      logic [ncl_pkg::THR_W-1:0] w;
      logic [ncl_pkg::THR_W-1:0] noise;
      w = '0;
      noise = ncl_pkg::thr_type'($urandom);
      if ($urandom_range(99) < 70)
         w[ncl_pkg::CNT_W-1:0] = ncl_pkg::cnt_type'($urandom_range(4, 1));
      else
         w[ncl_pkg::CNT_W-1:0] = ncl_pkg::cnt_type'($urandom_range(7, 0));
      // Upper bits of the write data carry noise now and then
      if ($urandom_range(3) == 0)
         w[ncl_pkg::THR_W-1:ncl_pkg::CNT_W] = noise[ncl_pkg::THR_W-1:ncl_pkg::CNT_W];
      return w;
   endfunction

   // Offer one request and hold it until taken
   task automatic push_point(point_type pt);
      int unsigned gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.distance_class_0 <= pt[0];
      req_bus.distance_class_1 <= pt[1];
      req_bus.distance_class_2 <= pt[2];
      req_bus.distance_class_3 <= pt[3];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_point(pt);
      points_sent++;
   endtask

   // Drop valid and hold off until every owed label has come back
   task automatic wait_for_labels();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   task automatic write_reg(ncl_pkg::csr_idx_type idx, logic [ncl_pkg::THR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      book.write_reg(idx, data);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic write_thresholds(int t0, int t1, int t2, int t3,
                                   logic [ncl_pkg::THR_W-1:0] cnt);
      write_reg(ncl_pkg::csr_idx_type'(ncl_pkg::CSR_THRESHOLD_BASE + 0),
                ncl_pkg::thr_type'(t0));
      write_reg(ncl_pkg::csr_idx_type'(ncl_pkg::CSR_THRESHOLD_BASE + 1),
                ncl_pkg::thr_type'(t1));
      write_reg(ncl_pkg::csr_idx_type'(ncl_pkg::CSR_THRESHOLD_BASE + 2),
                ncl_pkg::thr_type'(t2));
      write_reg(ncl_pkg::csr_idx_type'(ncl_pkg::CSR_THRESHOLD_BASE + 3),
                ncl_pkg::thr_type'(t3));
      write_reg(ncl_pkg::CSR_CLASS_COUNT, cnt);
      end_writes();
   endtask

   // Receiver: ready in runs, stalls between them
   initial begin
      int unsigned run;
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(99) < 70) ? $urandom_range(8, 1) : $urandom_range(120, 20);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = idle_on ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Check each label taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         book.check_label(rsp_bus.label);
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
         idle_cycles <= 0;
      else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      point_type pt;
      ncl_pkg::thr_type t [ncl_pkg::NUM_CLASSES];
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.distance_class_0 <= '0;
      req_bus.distance_class_1 <= '0;
      req_bus.distance_class_2 <= '0;
      req_bus.distance_class_3 <= '0;
      idle_on = 1'b1;
      points_sent = 0;
      settings_used = 1;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset thresholds: skip, ties, window edges, negative lanes
      push_point(mk(-1, 0, 0, 0));
      push_point(mk(-65536, 5, 5, 5));
      push_point(mk(0, 0, 0, 0));
      push_point(mk(65535, 0, 1229, 1229));
      push_point(mk(1229, 1229, 1229, 1229));
      push_point(mk(1230, 1229, 100, 100));
      push_point(mk(65535, -1, 65535, 0));
      push_point(mk(2000, -65536, 1230, -5));
      push_point(mk(614, 615, 1, 1228));
      wait_for_labels();

      // Zero thresholds, one and above one, exact tie by cross multiplication
      write_thresholds(0, 0, 4096, 8190, 13'd4);
      push_point(mk(0, 0, 0, 0));
      push_point(mk(1, 0, 0, 0));
      push_point(mk(1, 1, 2048, 4095));
      push_point(mk(1, 1, 2049, 4095));
      push_point(mk(0, 1, 4096, 8191));
      wait_for_labels();

      // Class count of zero acts as one
      write_thresholds(8191, 8191, 8191, 8191, 13'd0);
      push_point(mk(8191, 0, 0, 0));
      push_point(mk(8192, 0, 0, 0));
      wait_for_labels();

      // Class count beyond the lanes saturates
      write_reg(ncl_pkg::CSR_CLASS_COUNT, '1);
      end_writes();
      push_point(mk(8192, 8192, 8192, 0));
      wait_for_labels();

      // Two classes in use, skip still tested, unused indexes ignored
      write_reg(ncl_pkg::CSR_CLASS_COUNT, 13'd2);
      write_reg(3'd5, '1);
      write_reg(3'd6, 13'd7);
      write_reg(3'd7, 13'd1);
      end_writes();
      push_point(mk(8192, 8191, 0, 0));
      push_point(mk(-1, 0, 0, 0));
      push_point(mk(5, 5, 0, 0));
      wait_for_labels();

      // Random phases, each under its own register setting
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase % 4 != 2);
         if (phase == 0)
            write_thresholds(4096, 4096, 4096, 4096, 13'd4);
         else if (phase == 1)
            write_thresholds(1, 1, 1, 1, 13'd3);
         else begin
            for (int c = 0; c < ncl_pkg::NUM_CLASSES; c++)
               write_reg(ncl_pkg::csr_idx_type'(ncl_pkg::CSR_THRESHOLD_BASE + c),
                         pick_threshold());
            write_reg(ncl_pkg::CSR_CLASS_COUNT, pick_count());
            if ($urandom_range(9) < 3)
               write_reg(ncl_pkg::csr_idx_type'($urandom_range(7, 5)),
                         ncl_pkg::thr_type'($urandom));
            end_writes();
         end
         foreach (t[c]) t[c] = book.thr[c];
         for (int unsigned i = 0; i < POINTS_PER_PHASE; i++) begin
            foreach (pt[c]) pt[c] = pick_distance(t[c]);
            push_point(pt);
         end
         wait_for_labels();
      end

      idle_on = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d points under %0d register settings, %0d of them skipped",
               points_sent, settings_used, book.skipped);
      $display("labels seen: none %0d, class 1 %0d, class 2 %0d, class 3 %0d, class 4 %0d",
               book.label_seen[0], book.label_seen[1], book.label_seen[2],
               book.label_seen[3], book.label_seen[4]);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/ncl_pkg.sv
rtl/core/ncl_req_if.sv
rtl/core/ncl_rsp_if.sv
rtl/core/ncl_cell.sv
rtl/core/nearest_class_threshold_labeler_core.sv
verif/tb.sv
